/* hdl/rrts_pkg.sv */
// Shared codes, constants and control types of the round-robin task slot scheduler.
package rrts_pkg;

   // Request operation codes
   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_YIELD  = 2'd1;
   localparam logic [1:0] OP_EXIT   = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   // Response status codes
   localparam logic [1:0] RSP_DONE   = 2'd0;
   localparam logic [1:0] RSP_REJECT = 2'd1;
   localparam logic [1:0] RSP_ALONE  = 2'd2;

   // Slot status codes
   localparam logic [1:0] SLOT_UNUSED  = 2'd0;
   localparam logic [1:0] SLOT_READY   = 2'd1;
   localparam logic [1:0] SLOT_RUNNING = 2'd2;
   localparam logic [1:0] SLOT_ZOMBIE  = 2'd3;

   // Initial frame: one return word plus the saved register words
   localparam int unsigned REG_WORDS   = 8;
   localparam logic [31:0] FRAME_BYTES = 32'(4 * (REG_WORDS + 1));

   // Update commands from the sequencer to the slot table
   typedef struct packed {
      logic save_sp;      // store caller stack pointer into the running slot
      logic mark_exit;    // running slot becomes zombie, live count drops
      logic create;       // claim the selected slot as a new ready task
      logic switch_run;   // hand the running position to the selected slot
      logic demote_prev;  // old running slot goes back to ready
   } tbl_cmd_type;

   // Control of the slot scan unit
   typedef struct packed {
      logic start;
      logic step;
      logic is_create;
   } scan_ctl_type;

   // Status of the slot scan unit
   typedef struct packed {
      logic hit;
      logic last;
   } scan_sts_type;

endpackage

/* hdl/rrts_table.sv */
// Task slot table: per-slot status, saved stack pointer and entry, running slot, live count.
module rrts_table
   import rrts_pkg::*;
#(
   parameter int TASK_SLOTS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tbl_cmd_type                       cmd,
   input  logic [$clog2(TASK_SLOTS)-1:0]     sel_slot,
   input  logic [31:0]                       save_value,
   input  logic [31:0]                       create_sp,
   input  logic [31:0]                       create_entry,
   input  logic [$clog2(TASK_SLOTS)-1:0]     st_addr,
   input  logic [$clog2(TASK_SLOTS)-1:0]     rd_addr,
   output logic [1:0]                        st_rdata,
   output logic [31:0]                       stack_rdata,
   output logic [31:0]                       entry_rdata,
   output logic [$clog2(TASK_SLOTS)-1:0]     running,
   output logic [$clog2(TASK_SLOTS+1)-1:0]   live
);

   localparam int SLOT_W = $clog2(TASK_SLOTS);
   localparam int LIVE_W = $clog2(TASK_SLOTS + 1);

   logic [1:0]        status_ff  [TASK_SLOTS];
   logic [1:0]        status_in  [TASK_SLOTS];
   logic [31:0]       stack_ff   [TASK_SLOTS];
   logic [31:0]       stack_in   [TASK_SLOTS];
   logic [31:0]       entry_ff   [TASK_SLOTS];
   logic [31:0]       entry_in   [TASK_SLOTS];
   logic [SLOT_W-1:0] running_ff;
   logic [SLOT_W-1:0] running_in;
   logic [LIVE_W-1:0] live_ff;
   logic [LIVE_W-1:0] live_in;

   always_comb begin
      status_in  = status_ff;
      stack_in   = stack_ff;
      entry_in   = entry_ff;
      running_in = running_ff;
      live_in    = live_ff;
      if (cmd.save_sp) begin
         stack_in[running_ff] = save_value;
      end
      if (cmd.mark_exit) begin
         status_in[running_ff] = SLOT_ZOMBIE;
         if (live_ff != '0) begin
            live_in = live_ff - LIVE_W'(1);
         end
      end
      if (cmd.create) begin
         stack_in[sel_slot]  = create_sp;
         entry_in[sel_slot]  = create_entry;
         status_in[sel_slot] = SLOT_READY;
         live_in             = live_ff + LIVE_W'(1);
      end
      if (cmd.switch_run) begin
         if (cmd.demote_prev) begin
            status_in[running_ff] = SLOT_READY;
         end
         status_in[sel_slot] = SLOT_RUNNING;
         running_in          = sel_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            status_ff[i] <= (i == 0) ? SLOT_RUNNING : SLOT_UNUSED;
            stack_ff[i]  <= '0;
            entry_ff[i]  <= '0;
         end
         running_ff <= '0;
         live_ff    <= LIVE_W'(1);
      end else begin
         status_ff  <= status_in;
         stack_ff   <= stack_in;
         entry_ff   <= entry_in;
         running_ff <= running_in;
         live_ff    <= live_in;
      end
   end

   assign st_rdata    = status_ff[st_addr];
   assign stack_rdata = stack_ff[rd_addr];
   assign entry_rdata = entry_ff[rd_addr];
   assign running     = running_ff;
   assign live        = live_ff;

endmodule

/* hdl/rrts_scan.sv */
// Slot scan unit: walks the table one slot per cycle while step is high, through a single status comparator.
module rrts_scan
   import rrts_pkg::*;
#(
   parameter int TASK_SLOTS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  scan_ctl_type                  ctl,
   input  logic [$clog2(TASK_SLOTS)-1:0] running,
   input  logic [1:0]                    st_rdata,
   output logic [$clog2(TASK_SLOTS)-1:0] idx,
   output scan_sts_type                  sts
);

   localparam int SLOT_W = $clog2(TASK_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(TASK_SLOTS - 1);
   localparam logic [SLOT_W-1:0] CREATE_LAST = SLOT_W'(TASK_SLOTS - 1);
   localparam logic [SLOT_W-1:0] YIELD_LAST  = SLOT_W'(TASK_SLOTS - 2);

   logic [SLOT_W-1:0] idx_ff;
   logic [SLOT_W-1:0] idx_in;
   logic [SLOT_W-1:0] cnt_ff;
   logic [SLOT_W-1:0] cnt_in;
   logic              mode_ff;
   logic              mode_in;
   logic [1:0]        target;

   function automatic logic [SLOT_W-1:0] wrap_next(input logic [SLOT_W-1:0] cur);
      return (cur == LAST_SLOT) ? '0 : cur + SLOT_W'(1);
   endfunction

   always_comb begin
      idx_in  = idx_ff;
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      if (ctl.start) begin
         mode_in = ctl.is_create;
         idx_in  = ctl.is_create ? '0 : wrap_next(running);
         cnt_in  = '0;
      end else if (ctl.step) begin
         idx_in = wrap_next(idx_ff);
         cnt_in = cnt_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         cnt_ff  <= '0;
         mode_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         cnt_ff  <= cnt_in;
         mode_ff <= mode_in;
      end
   end

   // Create looks for a free slot, yield and exit for a ready one
   assign target   = mode_ff ? SLOT_UNUSED : SLOT_READY;
   assign idx      = idx_ff;
   assign sts.hit  = (st_rdata == target);
   assign sts.last = (cnt_ff == (mode_ff ? CREATE_LAST : YIELD_LAST));

endmodule

/* hdl/round_robin_task_slot_scheduler_top.sv */
// Top level of the round-robin task slot scheduler: sequencer, output register, config.
//
// Usage: a request word carries an operation (create, yield, exit), an entry
// address and the caller's stack pointer; it is accepted when req_valid is high
// and req_stall is low. Each create, yield or exit gives one response word with
// a status, the slot now running (or the created slot), the previous running
// slot, a switch flag and that slot's stack pointer and entry address (both zero on a reject). The
// unused operation code is taken and dropped with no response.
// The slot scan tests one table entry per cycle through a single status
// comparator; a create rejected up front skips the scan. One request is in
// flight at a time and req_stall stays high until its response is loaded into
// the output register, so the next request can be taken while that response
// still waits.
// csr_wr_en/csr_wr_data load the stack region base; write it only when idle.
// Reset: slot 0 runs, all other slots are unused, live count is one, the stack
// region base is zero and no response is pending.
// When rsp_stall is high the response word holds, and a finished request waits
// in its last step until the output register frees up.
module round_robin_task_slot_scheduler_top
   import rrts_pkg::*;
#(
   parameter int TASK_SLOTS  = 4,
   parameter int STACK_BYTES = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [31:0]                   csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_operation,
   input  logic [31:0]                   req_entry_address,
   input  logic [31:0]                   req_stack_pointer,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [$clog2(TASK_SLOTS)-1:0] rsp_slot_id,
   output logic [$clog2(TASK_SLOTS)-1:0] rsp_previous_slot,
   output logic                          rsp_switched,
   output logic [31:0]                   rsp_next_stack_pointer,
   output logic [31:0]                   rsp_next_entry_address
);

   localparam int SLOT_W = $clog2(TASK_SLOTS);
   localparam int LIVE_W = $clog2(TASK_SLOTS + 1);
   localparam logic [31:0]       STACK_STEP = 32'(STACK_BYTES);
   localparam logic [LIVE_W-1:0] LIVE_FULL  = LIVE_W'(TASK_SLOTS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff,     state_in;
   logic [31:0]       base_ff,      base_in;
   logic              is_create_ff, is_create_in;
   logic              reject_ff,    reject_in;
   logic              found_ff,     found_in;
   logic [SLOT_W-1:0] found_id_ff,  found_id_in;
   logic              demote_ff,    demote_in;
   logic [31:0]       entry_ff,     entry_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0] rsp_slot_ff,  rsp_slot_in;
   logic [SLOT_W-1:0] rsp_prev_ff,  rsp_prev_in;
   logic              rsp_sw_ff,    rsp_sw_in;
   logic [31:0]       rsp_sp_ff,    rsp_sp_in;
   logic [31:0]       rsp_entry_ff, rsp_entry_in;

   tbl_cmd_type       cmd;
   scan_ctl_type      scan_ctl;
   scan_sts_type      scan_sts;
   logic [SLOT_W-1:0] scan_idx;
   logic [SLOT_W-1:0] st_addr;
   logic [SLOT_W-1:0] rd_addr;
   logic [1:0]        st_rdata;
   logic [31:0]       stack_rdata;
   logic [31:0]       entry_rdata;
   logic [SLOT_W-1:0] running;
   logic [LIVE_W-1:0] live;
   logic [SLOT_W:0]   slot_num;
   logic [31:0]       frame_sp;
   logic              req_accept;
   logic              out_free;

   rrts_table #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_table (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sel_slot     (found_id_ff),
      .save_value   (req_stack_pointer),
      .create_sp    (frame_sp),
      .create_entry (entry_ff),
      .st_addr      (st_addr),
      .rd_addr      (rd_addr),
      .st_rdata     (st_rdata),
      .stack_rdata  (stack_rdata),
      .entry_rdata  (entry_rdata),
      .running      (running),
      .live         (live)
   );

   rrts_scan #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctl      (scan_ctl),
      .running  (running),
      .st_rdata (st_rdata),
      .idx      (scan_idx),
      .sts      (scan_sts)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign st_addr    = (state_ff == ST_IDLE) ? running : scan_idx;
   assign rd_addr    = found_ff ? found_id_ff : running;

   // Initial stack pointer of a new slot: its stack top less the start frame
   assign slot_num = (SLOT_W + 1)'(found_id_ff) + (SLOT_W + 1)'(1);
   assign frame_sp = base_ff + 32'(slot_num) * STACK_STEP - FRAME_BYTES;

   always_comb begin
      state_in      = state_ff;
      base_in       = csr_wr_en ? csr_wr_data : base_ff;
      is_create_in  = is_create_ff;
      reject_in     = reject_ff;
      found_in      = found_ff;
      found_id_in   = found_id_ff;
      demote_in     = demote_ff;
      entry_in      = entry_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_prev_in   = rsp_prev_ff;
      rsp_sw_in     = rsp_sw_ff;
      rsp_sp_in     = rsp_sp_ff;
      rsp_entry_in  = rsp_entry_ff;
      cmd           = '0;
      scan_ctl      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               found_in = 1'b0;
               unique case (req_operation)
                  OP_CREATE: begin
                     is_create_in = 1'b1;
                     entry_in     = req_entry_address;
                     if (req_entry_address == '0 || live >= LIVE_FULL) begin
                        reject_in = 1'b1;
                        state_in  = ST_DONE;
                     end else begin
                        reject_in          = 1'b0;
                        scan_ctl.start     = 1'b1;
                        scan_ctl.is_create = 1'b1;
                        state_in           = ST_SCAN;
                     end
                  end
                  OP_YIELD, OP_EXIT: begin
                     is_create_in   = 1'b0;
                     reject_in      = 1'b0;
                     cmd.save_sp    = 1'b1;
                     // a zombie stays zombie and is never counted twice
                     cmd.mark_exit  = (req_operation == OP_EXIT) &&
                                      (st_rdata != SLOT_ZOMBIE);
                     demote_in      = (req_operation == OP_YIELD) &&
                                      (st_rdata == SLOT_RUNNING);
                     scan_ctl.start = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  OP_NOP: begin
                     // drop: no response, no state change
                  end
               endcase
            end
         end
         ST_SCAN: begin
            priority if (scan_sts.hit) begin
               found_in    = 1'b1;
               found_id_in = scan_idx;
               state_in    = ST_DONE;
            end else if (scan_sts.last) begin
               state_in = ST_DONE;
            end else begin
               scan_ctl.step = 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_prev_in  = running;
               priority if (is_create_ff && (reject_ff || !found_ff)) begin
                  rsp_status_in = RSP_REJECT;
                  rsp_slot_in   = running;
                  rsp_sw_in     = 1'b0;
                  rsp_sp_in     = '0;
                  rsp_entry_in  = '0;
               end else if (is_create_ff) begin
                  cmd.create    = 1'b1;
                  rsp_status_in = RSP_DONE;
                  rsp_slot_in   = found_id_ff;
                  rsp_sw_in     = 1'b0;
                  rsp_sp_in     = frame_sp;
                  rsp_entry_in  = entry_ff;
               end else if (found_ff) begin
                  cmd.switch_run  = 1'b1;
                  cmd.demote_prev = demote_ff;
                  rsp_status_in   = RSP_DONE;
                  rsp_slot_in     = found_id_ff;
                  rsp_sw_in       = 1'b1;
                  rsp_sp_in       = stack_rdata;
                  rsp_entry_in    = entry_rdata;
               end else begin
                  rsp_status_in = RSP_ALONE;
                  rsp_slot_in   = running;
                  rsp_sw_in     = 1'b0;
                  rsp_sp_in     = stack_rdata;
                  rsp_entry_in  = entry_rdata;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         is_create_ff <= 1'b0;
         reject_ff    <= 1'b0;
         found_ff     <= 1'b0;
         demote_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
         is_create_ff <= is_create_in;
         reject_ff    <= reject_in;
         found_ff     <= found_in;
         demote_ff    <= demote_in;
      end
   end

   always_ff @(posedge clock) begin
      found_id_ff   <= found_id_in;
      entry_ff      <= entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_prev_ff   <= rsp_prev_in;
      rsp_sw_ff     <= rsp_sw_in;
      rsp_sp_ff     <= rsp_sp_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_slot_id            = rsp_slot_ff;
   assign rsp_previous_slot      = rsp_prev_ff;
   assign rsp_switched           = rsp_sw_ff;
   assign rsp_next_stack_pointer = rsp_sp_ff;
   assign rsp_next_entry_address = rsp_entry_ff;

   // A new response word is only loaded from the final sequencer step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("response word appeared outside the final step");

   // A switch always names a different slot than the one left behind
   a_switch_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_switched) |-> (rsp_slot_id != rsp_previous_slot))
      else $error("switch reported onto the same slot");

   // Any real operation keeps the request side busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_operation != OP_NOP) |=> req_stall)
      else $error("request side free right after taking an operation");

   // Live task count never exceeds the table size
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live <= LIVE_FULL)
      else $error("live task count beyond table size");

endmodule

/* tb/round_robin_task_slot_scheduler_top_tb.sv */
// Self-checking testbench for the round-robin task slot scheduler with a scoreboard class.
`timescale 1ns / 1ps

module round_robin_task_slot_scheduler_top_tb;
   import rrts_pkg::*;

   localparam int SLOTS       = 4;
   localparam int STACK_BYTES = 4096;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int SETTLE      = SLOTS + 4;
   localparam int LONG_HOLD   = 300;
   localparam int QUIET_LIMIT = 2000;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot_id;
      logic [SLOT_W-1:0] previous_slot;
      logic              switched;
      logic [31:0]       next_sp;
      logic [31:0]       next_entry;
   } sched_rsp_t;

   // Task table shadow and queue of scheduler words still to come
   class sched_scoreboard;
      logic [1:0]  slot_state [SLOTS];
      logic [31:0] saved_sp [SLOTS];
      logic [31:0] entry_of [SLOTS];
      int unsigned running;
      int unsigned live;
      logic [31:0] region_base;
      sched_rsp_t  expected_q [$];
      int unsigned errors;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            slot_state[i] = SLOT_UNUSED;
            saved_sp[i]   = '0;
            entry_of[i]   = '0;
         end
         slot_state[0] = SLOT_RUNNING;
         running       = 0;
         live          = 1;
         region_base   = '0;
         errors        = 0;
      endfunction

      // Save the caller's stack and pass the slot to the next ready one
      function sched_rsp_t hand_over(logic [31:0] sp);
         sched_rsp_t  r;
         int unsigned prev;
         int unsigned nxt;
         int unsigned id;
         prev = running;
         nxt  = prev;
         saved_sp[prev] = sp;
         for (int s = 1; s < SLOTS; s++) begin
            id = (prev + s) % SLOTS;
            if (nxt == prev && slot_state[id] == SLOT_READY)
               nxt = id;
         end
         r.previous_slot = SLOT_W'(prev);
         if (nxt == prev) begin
            r.status   = RSP_ALONE;
            r.slot_id  = SLOT_W'(prev);
            r.switched = 1'b0;
         end else begin
            if (slot_state[prev] == SLOT_RUNNING)
               slot_state[prev] = SLOT_READY;
            slot_state[nxt] = SLOT_RUNNING;
            running    = nxt;
            r.status   = RSP_DONE;
            r.slot_id  = SLOT_W'(nxt);
            r.switched = 1'b1;
         end
         r.next_sp    = saved_sp[nxt];
         r.next_entry = entry_of[nxt];
         return r;
      endfunction

      function void note_request(logic [1:0] op, logic [31:0] entry, logic [31:0] sp);
         sched_rsp_t  r;
         int unsigned free_id;
         bit          found;
         r               = '0;
         r.slot_id       = SLOT_W'(running);
         r.previous_slot = SLOT_W'(running);
         found           = 1'b0;
         free_id         = 0;
         case (op)
            OP_CREATE: begin
               r.status = RSP_REJECT;
               if (entry != '0 && live < SLOTS) begin
                  for (int i = SLOTS - 1; i >= 0; i--) begin
                     if (slot_state[i] == SLOT_UNUSED) begin
                        found   = 1'b1;
                        free_id = i;
                     end
                  end
               end
               if (found) begin
                  saved_sp[free_id]   = region_base + 32'((free_id + 1) * STACK_BYTES)
                                        - FRAME_BYTES;
                  entry_of[free_id]   = entry;
                  slot_state[free_id] = SLOT_READY;
                  live++;
                  r.status     = RSP_DONE;
                  r.slot_id    = SLOT_W'(free_id);
                  r.next_sp    = saved_sp[free_id];
                  r.next_entry = entry;
               end
               expected_q.push_back(r);
            end
            OP_YIELD: expected_q.push_back(hand_over(sp));
            OP_EXIT: begin
               // a zombie that exits again does not drop the live count twice
               if (slot_state[running] != SLOT_ZOMBIE) begin
                  slot_state[running] = SLOT_ZOMBIE;
                  if (live > 0)
                     live--;
               end
               expected_q.push_back(hand_over(sp));
            end
            default: ;   // drop: no word comes back
         endcase
      endfunction

      function void check_response(sched_rsp_t got);
         sched_rsp_t want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected word status=%0d slot=%0d prev=%0d sw=%0d sp=%h entry=%h",
                     $time, got.status, got.slot_id, got.previous_slot, got.switched,
                     got.next_sp, got.next_entry);
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status || got.slot_id !== want.slot_id ||
             got.previous_slot !== want.previous_slot || got.switched !== want.switched ||
             got.next_sp !== want.next_sp || got.next_entry !== want.next_entry) begin
            errors++;
            $display("%0t: expected status=%0d slot=%0d prev=%0d sw=%0d sp=%h entry=%h",
                     $time, want.status, want.slot_id, want.previous_slot, want.switched,
                     want.next_sp, want.next_entry);
            $display("%0t: actual   status=%0d slot=%0d prev=%0d sw=%0d sp=%h entry=%h",
                     $time, got.status, got.slot_id, got.previous_slot, got.switched,
                     got.next_sp, got.next_entry);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [31:0]       csr_wr_data;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_operation;
   logic [31:0]       req_entry_address;
   logic [31:0]       req_stack_pointer;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [1:0]        rsp_status;
   logic [SLOT_W-1:0] rsp_slot_id;
   logic [SLOT_W-1:0] rsp_previous_slot;
   logic              rsp_switched;
   logic [31:0]       rsp_next_stack_pointer;
   logic [31:0]       rsp_next_entry_address;

   sched_scoreboard sb = new();
   bit              tx_idle_on;
   bit              rx_idle_on;
   int unsigned     long_holds_wanted = 0;
   int unsigned     long_holds_done = 0;
   int unsigned     quiet_cycles = 0;

   round_robin_task_slot_scheduler_top #(
      .TASK_SLOTS  (SLOTS),
      .STACK_BYTES (STACK_BYTES)
   ) u_top (
      .clock                  (clock),
      .reset                  (reset),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_operation          (req_operation),
      .req_entry_address      (req_entry_address),
      .req_stack_pointer      (req_stack_pointer),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_slot_id            (rsp_slot_id),
      .rsp_previous_slot      (rsp_previous_slot),
      .rsp_switched           (rsp_switched),
      .rsp_next_stack_pointer (rsp_next_stack_pointer),
      .rsp_next_entry_address (rsp_next_entry_address)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin : monitor
      sched_rsp_t seen;
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_operation, req_entry_address, req_stack_pointer);
         if (rsp_valid && !rsp_stall) begin
            seen.status        = rsp_status;
            seen.slot_id       = rsp_slot_id;
            seen.previous_slot = rsp_previous_slot;
            seen.switched      = rsp_switched;
            seen.next_sp       = rsp_next_stack_pointer;
            seen.next_entry    = rsp_next_entry_address;
            sb.check_response(seen);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: stall before each word, at random while rx_idle_on, or a long hold
   initial begin : rsp_side
      int unsigned hold;
      rsp_stall = 1'b0;
      forever begin
         if (long_holds_done != long_holds_wanted) begin
            hold = LONG_HOLD;
            long_holds_done++;
         end else begin
            hold = rx_idle_on ? $urandom_range(0, 19) : 0;
         end
         @(negedge clock);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_word(input logic [1:0] op, input logic [31:0] entry,
                            input logic [31:0] sp);
      int unsigned gap;
      gap = tx_idle_on ? $urandom_range(0, 19) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_entry_address <= entry;
      req_stack_pointer <= sp;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random(input int unsigned exit_odds);
      logic [1:0]  op;
      logic [31:0] entry;
      logic [31:0] sp;
      int unsigned pick;
      pick  = $urandom_range(0, 99);
      entry = $urandom;
      sp    = $urandom;
      case ($urandom_range(0, 15))
         0: sp = '0;
         1: sp = '1;
         2: entry = '1;
         default: ;
      endcase
      if (pick < exit_odds) begin
         op = OP_EXIT;
      end else if (pick < 70) begin
         op = OP_YIELD;
      end else if (pick < 92) begin
         op = OP_CREATE;
         if ($urandom_range(0, 3) == 0)
            entry = '0;
      end else begin
         op = OP_NOP;
      end
      send_word(op, entry, sp);
   endtask

   // Stop offering, then hold until every word is back and the block is quiet
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_region_base(input logic [31:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en      <= 1'b0;
      sb.region_base  = value;
   endtask

   initial begin : stimulus
      int unsigned p;
      int unsigned n;
      int unsigned count;
      logic [31:0] base;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_valid         = 1'b0;
      req_operation     = OP_NOP;
      req_entry_address = '0;
      req_stack_pointer = '0;
      tx_idle_on        = 1'b1;
      rx_idle_on        = 1'b1;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // top of region wraps past zero for slot 1
      write_region_base(32'hFFFF_FFFF);
      send_word(OP_YIELD, 32'h0, 32'hFFFF_FFFF);
      send_word(OP_NOP, 32'hFFFF_FFFF, 32'h0);
      send_word(OP_CREATE, 32'h0, 32'h0);
      send_word(OP_CREATE, 32'hFFFF_FFFF, 32'h0);
      send_word(OP_YIELD, 32'h0, 32'h0);
      send_word(OP_YIELD, 32'h0, 32'h1234_5678);
      drain();

      write_region_base(32'h0);
      send_word(OP_CREATE, 32'h1, 32'hFFFF_FFFF);
      send_word(OP_YIELD, 32'h0, $urandom);
      send_word(OP_YIELD, 32'h0, $urandom);
      send_word(OP_YIELD, 32'h0, $urandom);
      drain();

      // fill the table, then a create with no slot left
      write_region_base($urandom);
      send_word(OP_CREATE, $urandom | 32'h1, $urandom);
      send_word(OP_CREATE, $urandom | 32'h1, $urandom);
      drain();

      for (p = 0; p < 7; p++) begin
         case (p)
            1:       base = 32'hFFFF_FFFF;
            3:       base = 32'h0;
            5:       base = 32'hFFFF_F000;
            default: base = $urandom;
         endcase
         write_region_base(base);
         tx_idle_on = (p % 2 == 0);
         rx_idle_on = ((p / 2) % 2 == 0);
         count = (p < 5) ? 240 : 225;
         for (n = 0; n < count; n++) begin
            if (p == 3 && n == 40)
               long_holds_wanted++;
            send_random((p < 5) ? 0 : 3);
         end
         drain();
      end

      // retire every task, then exit once more as a zombie
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      repeat (5) send_word(OP_EXIT, $urandom, $urandom);
      send_word(OP_YIELD, $urandom, $urandom);
      send_word(OP_CREATE, 32'h1, $urandom);
      send_word(OP_NOP, $urandom, $urandom);
      drain();

      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

/* files.f */
hdl/rrts_pkg.sv
hdl/rrts_table.sv
hdl/rrts_scan.sv
hdl/round_robin_task_slot_scheduler_top.sv
tb/round_robin_task_slot_scheduler_top_tb.sv
